### rtl/dnsare_pkg.sv
// shared types and constants for the dns answer record extractor
`default_nettype none

package dnsare_pkg;

   localparam int OFFSET_WIDTH = 16;

   typedef logic [OFFSET_WIDTH-1:0] offset_type;

   typedef enum logic [2:0] {
      KIND_ADDRESS = 3'd0,
      KIND_ALIAS   = 3'd1,
      KIND_POINTER = 3'd2,
      KIND_MAIL    = 3'd3,
      KIND_SUMMARY = 3'd4
   } result_kind_type;

   // one result item as it sits in the output queue
   typedef struct packed {
      result_kind_type kind;
      logic [15:0]     answer_index;
      logic [31:0]     time_to_live;
      logic [31:0]     ipv4_address;
      logic [15:0]     mail_preference;
      logic [15:0]     target_name_offset;
      logic [15:0]     record_data_length;
      logic [3:0]      response_code;
      logic            any_found;
      logic            too_short;
      logic            last_of_run;
   } rsp_item_type;

   // results produced by one accepted byte: none, a record, the summary, or both
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } parse_out_type;

   localparam int TDATA_WIDTH = 136;

endpackage

`default_nettype wire

### rtl/dnsare_parser.sv
// byte-wise dns message walker: header, questions, answer records
`default_nettype none

module dnsare_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    byte_valid,
   input  wire logic [7:0]              message_byte,
   input  wire logic                    final_byte,
   output dnsare_pkg::parse_out_type    parse_out
);
   import dnsare_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_QNAME  = 3'd1,
      PH_QFIXED = 3'd2,
      PH_ANAME  = 3'd3,
      PH_AFIXED = 3'd4,
      PH_RDATA  = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   localparam logic [15:0] TYPE_A     = 16'd1;
   localparam logic [15:0] TYPE_CNAME = 16'd5;
   localparam logic [15:0] TYPE_PTR   = 16'd12;
   localparam logic [15:0] TYPE_MX    = 16'd15;
   localparam logic [7:0]  PTR_MASK   = 8'hC0;
   localparam logic [7:0]  RCODE_MASK = 8'h0F;

   offset_type  offset_ff, offset_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] qcount_ff, qcount_in;
   logic [15:0] acount_ff, acount_in;
   logic [3:0]  rcode_ff, rcode_in;
   logic [15:0] sic_ff, sic_in;
   logic [15:0] skip_ff, skip_in;
   logic [3:0]  fbi_ff, fbi_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [15:0] rlen_ff, rlen_in;
   offset_type  rstart_ff, rstart_in;
   logic [31:0] acc_ff, acc_in;
   logic        found_ff, found_in;

   logic         name_done;
   logic         do_finish;
   logic         rec_valid;
   logic         start_ans;
   rsp_item_type rec_item;
   rsp_item_type sum_item;

   always_comb begin
      offset_in = offset_ff + 1'b1;
      phase_in  = phase_ff;
      qcount_in = qcount_ff;
      acount_in = acount_ff;
      rcode_in  = rcode_ff;
      sic_in    = sic_ff;
      skip_in   = skip_ff;
      fbi_in    = fbi_ff;
      rtype_in  = rtype_ff;
      ttl_in    = ttl_ff;
      rlen_in   = rlen_ff;
      rstart_in = rstart_ff;
      acc_in    = acc_ff;
      found_in  = found_ff;
      name_done = 1'b0;
      do_finish = 1'b0;
      rec_valid = 1'b0;
      start_ans = 1'b0;
      rec_item  = '0;
      sum_item  = '0;

      // label / pointer skipping shared by question and answer names
      if (fbi_ff == 4'd1) begin
         name_done = 1'b1;
         fbi_in    = 4'd0;
      end else if (skip_ff != 16'd0) begin
         skip_in = skip_ff - 1'b1;
      end else if (message_byte == 8'd0) begin
         name_done = 1'b1;
      end else if ((message_byte & PTR_MASK) == PTR_MASK) begin
         fbi_in = 4'd1;
      end else begin
         skip_in = {8'd0, message_byte};
      end

      unique case (phase_ff)
         PH_HEADER: begin
            skip_in = skip_ff;
            fbi_in  = fbi_ff;
            if (offset_ff == offset_type'(3)) begin
               rcode_in = 4'(message_byte & RCODE_MASK);
            end else if (offset_ff == offset_type'(4)) begin
               qcount_in = {message_byte, 8'd0};
            end else if (offset_ff == offset_type'(5)) begin
               qcount_in = qcount_ff | {8'd0, message_byte};
            end else if (offset_ff == offset_type'(6)) begin
               acount_in = {message_byte, 8'd0};
            end else if (offset_ff == offset_type'(7)) begin
               acount_in = acount_ff | {8'd0, message_byte};
            end else if (offset_ff == offset_type'(11)) begin
               if (qcount_ff == 16'd0) begin
                  start_ans = 1'b1;
               end else begin
                  sic_in   = 16'd0;
                  fbi_in   = 4'd0;
                  skip_in  = 16'd0;
                  phase_in = PH_QNAME;
               end
            end
         end
         PH_QNAME, PH_ANAME: begin
            if (name_done) begin
               fbi_in   = 4'd0;
               phase_in = (phase_ff == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
            end
         end
         PH_QFIXED: begin
            skip_in = skip_ff;
            fbi_in  = fbi_ff + 1'b1;
            if (fbi_in >= 4'd4) begin
               fbi_in = 4'd0;
               sic_in = sic_ff + 1'b1;
               if (sic_in == qcount_ff) begin
                  start_ans = 1'b1;
               end else begin
                  phase_in = PH_QNAME;
               end
            end
         end
         PH_AFIXED: begin
            skip_in = skip_ff;
            if (fbi_ff == 4'd0) begin
               rtype_in = {message_byte, 8'd0};
            end else if (fbi_ff == 4'd1) begin
               rtype_in = rtype_ff | {8'd0, message_byte};
            end else if (fbi_ff >= 4'd4 && fbi_ff <= 4'd7) begin
               ttl_in = {ttl_ff[23:0], message_byte};
            end else if (fbi_ff == 4'd8) begin
               rlen_in = {message_byte, 8'd0};
            end else if (fbi_ff == 4'd9) begin
               rlen_in = rlen_ff | {8'd0, message_byte};
            end
            fbi_in = fbi_ff + 1'b1;
            if (fbi_in >= 4'd10) begin
               fbi_in    = 4'd0;
               acc_in    = 32'd0;
               rstart_in = offset_ff + 1'b1;
               skip_in   = rlen_in;
               if (rlen_in == 16'd0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = PH_RDATA;
               end
            end
         end
         PH_RDATA: begin
            fbi_in  = fbi_ff;
            skip_in = skip_ff;
            if (fbi_ff < 4'd4) begin
               acc_in = {acc_ff[23:0], message_byte};
               fbi_in = fbi_ff + 1'b1;
            end
            if (skip_ff != 16'd0) begin
               skip_in = skip_ff - 1'b1;
            end
            if (skip_in == 16'd0) begin
               do_finish = 1'b1;
            end
         end
         default: begin
            skip_in = skip_ff;
            fbi_in  = fbi_ff;
         end
      endcase

      if (start_ans) begin
         sic_in   = 16'd0;
         fbi_in   = 4'd0;
         skip_in  = 16'd0;
         phase_in = (acount_in == 16'd0) ? PH_DONE : PH_ANAME;
      end

      if (do_finish) begin
         if (rtype_in == TYPE_A && rlen_in == 16'd4) begin
            rec_valid             = 1'b1;
            rec_item.kind         = KIND_ADDRESS;
            rec_item.ipv4_address = acc_in;
         end else if (rtype_in == TYPE_CNAME) begin
            rec_valid                   = 1'b1;
            rec_item.kind               = KIND_ALIAS;
            rec_item.target_name_offset = 16'(rstart_in);
         end else if (rtype_in == TYPE_PTR) begin
            rec_valid                   = 1'b1;
            rec_item.kind               = KIND_POINTER;
            rec_item.target_name_offset = 16'(rstart_in);
         end else if (rtype_in == TYPE_MX && rlen_in >= 16'd2) begin
            rec_valid                   = 1'b1;
            rec_item.kind               = KIND_MAIL;
            rec_item.target_name_offset = 16'(offset_type'(rstart_in + 2'd2));
            if (rlen_in >= 16'd4) begin
               rec_item.mail_preference = acc_in[31:16];
            end else if (rlen_in == 16'd3) begin
               rec_item.mail_preference = acc_in[23:8];
            end else begin
               rec_item.mail_preference = acc_in[15:0];
            end
         end
         if (rec_valid) begin
            rec_item.answer_index       = sic_in;
            rec_item.time_to_live       = ttl_in;
            rec_item.record_data_length = rlen_in;
            rec_item.last_of_run        = ~final_byte;
            found_in                    = 1'b1;
         end
         sic_in   = sic_in + 1'b1;
         fbi_in   = 4'd0;
         skip_in  = 16'd0;
         phase_in = (sic_in == acount_in) ? PH_DONE : PH_ANAME;
      end

      // end of message: summary, then everything back to its reset value
      if (final_byte) begin
         sum_item.kind        = KIND_SUMMARY;
         sum_item.too_short   = (phase_in == PH_HEADER);
         sum_item.response_code = (phase_in == PH_HEADER) ? 4'd0 : rcode_in;
         sum_item.any_found   = (phase_in == PH_HEADER) ? 1'b0 : found_in;
         sum_item.last_of_run = 1'b1;
         offset_in = '0;
         phase_in  = PH_HEADER;
         qcount_in = 16'd0;
         acount_in = 16'd0;
         rcode_in  = 4'd0;
         sic_in    = 16'd0;
         skip_in   = 16'd0;
         fbi_in    = 4'd0;
         rtype_in  = 16'd0;
         ttl_in    = 32'd0;
         rlen_in   = 16'd0;
         rstart_in = '0;
         acc_in    = 32'd0;
         found_in  = 1'b0;
      end

      parse_out.count  = byte_valid ? (2'(rec_valid) + 2'(final_byte)) : 2'd0;
      parse_out.first  = rec_valid ? rec_item : sum_item;
      parse_out.second = sum_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         phase_ff  <= PH_HEADER;
         qcount_ff <= 16'd0;
         acount_ff <= 16'd0;
         rcode_ff  <= 4'd0;
         sic_ff    <= 16'd0;
         skip_ff   <= 16'd0;
         fbi_ff    <= 4'd0;
         rtype_ff  <= 16'd0;
         ttl_ff    <= 32'd0;
         rlen_ff   <= 16'd0;
         rstart_ff <= '0;
         acc_ff    <= 32'd0;
         found_ff  <= 1'b0;
      end else if (byte_valid) begin
         offset_ff <= offset_in;
         phase_ff  <= phase_in;
         qcount_ff <= qcount_in;
         acount_ff <= acount_in;
         rcode_ff  <= rcode_in;
         sic_ff    <= sic_in;
         skip_ff   <= skip_in;
         fbi_ff    <= fbi_in;
         rtype_ff  <= rtype_in;
         ttl_ff    <= ttl_in;
         rlen_ff   <= rlen_in;
         rstart_ff <= rstart_in;
         acc_ff    <= acc_in;
         found_ff  <= found_in;
      end
   end

endmodule

`default_nettype wire

### rtl/dns_answer_record_extractor.sv
// top level: dns response byte stream in, extracted answer records out
// a result is written into the registered output queue when the byte that causes it is accepted
// throughput: one message byte per cycle while req_tready is high; a byte yields at most two results
// req_tready drops only while two or more results wait in the three-entry queue
// reset: synchronous, active high; clears parse state and empties the queue
`default_nettype none

module dns_answer_record_extractor (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream: one message byte per transaction
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] message_byte
   input  wire logic         req_tlast,   // final_byte
   // response stream: one extracted record or the end summary per transaction
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [15:0] answer_index, [47:16] time_to_live, [79:48] ipv4_address,
   // [95:80] mail_preference, [111:96] target_name_offset,
   // [127:112] record_data_length, [131:128] response_code, [132] any_found,
   // [133] too_short, [135:134] zero
   output      logic [dnsare_pkg::TDATA_WIDTH-1:0] rsp_tdata,
   output      logic [2:0]   rsp_tuser,   // [2:0] result_kind
   output      logic         rsp_tlast    // last_of_run
);
   import dnsare_pkg::*;

   localparam int QDEPTH = 3;

   logic          req_accept;
   logic          rsp_pop;
   parse_out_type parse_out;

   // output queue: entry 0 is the head and drives the rsp port
   rsp_item_type  q_ff [QDEPTH];
   rsp_item_type  q_in [QDEPTH];
   rsp_item_type  shifted [QDEPTH];
   logic [1:0]    cnt_ff, cnt_in;
   logic [1:0]    base;

   // room for the worst case of two results per byte
   assign req_tready = (cnt_ff <= 2'd1);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_pop    = rsp_tvalid & rsp_tready;

   dnsare_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_accept),
      .message_byte (req_tdata),
      .final_byte   (req_tlast),
      .parse_out    (parse_out)
   );

   // pop shifts the queue down, new results append behind what remains
   always_comb begin
      shifted[0] = rsp_pop ? q_ff[1] : q_ff[0];
      shifted[1] = rsp_pop ? q_ff[2] : q_ff[1];
      shifted[2] = q_ff[2];
      base   = cnt_ff - 2'(rsp_pop);
      cnt_in = base + parse_out.count;
      for (int i = 0; i < QDEPTH; i++) begin
         q_in[i] = shifted[i];
         if (parse_out.count != 2'd0 && 2'(i) == base) begin
            q_in[i] = parse_out.first;
         end else if (parse_out.count == 2'd2 && 2'(i) == base + 2'd1) begin
            q_in[i] = parse_out.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // head entry onto the stream ports
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tuser  = q_ff[0].kind;
   assign rsp_tlast  = q_ff[0].last_of_run;
   assign rsp_tdata  = {2'b00,
                        q_ff[0].too_short,
                        q_ff[0].any_found,
                        q_ff[0].response_code,
                        q_ff[0].record_data_length,
                        q_ff[0].target_name_offset,
                        q_ff[0].mail_preference,
                        q_ff[0].ipv4_address,
                        q_ff[0].time_to_live,
                        q_ff[0].answer_index};

   // the end of a message always leaves its summary in the queue
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> rsp_tvalid)
      else $error("summary missing after final byte");

   // the summary always closes the run of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SUMMARY |-> rsp_tlast)
      else $error("summary not marked last");

   // records never carry summary fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_SUMMARY |-> rsp_tdata[133:128] == 6'd0)
      else $error("summary bits set on a record");

   // queue is empty right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

`default_nettype wire
